// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/irpw_pkg.sv =====
package irpw_pkg;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_EDGE    = 2'd1,
		KIND_READ    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	localparam logic [15:0] WIDTH_MAX       = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_DEFAULT = 16'd10000;

	// ring geometry; the status and port widths are sized for these
	localparam int FRAME_SLOTS    = 5;
	localparam int FRAME_CAPACITY = 128;
	localparam int STORE_AW       = $clog2(FRAME_SLOTS * FRAME_CAPACITY);

	// per-word status from the frame controller
	typedef struct packed {
		logic       read_valid;
		logic [2:0] frames_ready;
		logic [6:0] oldest_length;
		logic       frame_closed;
		logic       overrun;
	} status_t;

endpackage

// ===== rtl/irpw_ram.sv =====
module irpw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/irpw_ctrl.sv =====
module irpw_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  irpw_pkg::kind_t                 kind,
	input  logic [6:0]                      read_index,
	input  logic                            cfg_we,
	input  logic [15:0]                     cfg_wdata,
	output irpw_pkg::status_t               status,
	output logic                            ram_we,
	output logic [irpw_pkg::STORE_AW-1:0]   ram_waddr,
	output logic [15:0]                     ram_wdata,
	output logic                            ram_re,
	output logic [irpw_pkg::STORE_AW-1:0]   ram_raddr
);

	import irpw_pkg::*;

	localparam int SW = $clog2(FRAME_SLOTS);
	localparam int RW = $clog2(FRAME_SLOTS + 1);
	localparam int LW = $clog2(FRAME_CAPACITY);
	localparam int AW = $clog2(FRAME_SLOTS * FRAME_CAPACITY);

	logic [15:0]   timeout_q;
	logic [15:0]   cnt_q, cnt_d, cnt_inc;
	logic          skip_q, skip_d;
	logic [LW-1:0] fill_q, fill_d, fill_inc, close_len;
	logic [SW-1:0] ws_q, ws_d, rs_q, rs_d, rd_slot;
	logic [RW-1:0] ready_q, ready_d;
	logic          overrun_q, overrun_d;
	logic [LW-1:0] slot_len_q [FRAME_SLOTS];
	logic [LW-1:0] len_rd, oldest;
	logic          closing, len_we, read_hit, ring_full, ring_any;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		return (s == SW'(FRAME_SLOTS - 1)) ? '0 : s + SW'(1);
	endfunction

	assign ring_full = (ready_q == RW'(FRAME_SLOTS));
	assign ring_any  = (ready_q != '0);
	assign cnt_inc   = (cnt_q != WIDTH_MAX) ? cnt_q + 16'd1 : cnt_q;
	assign fill_inc  = fill_q + LW'(1);

	// one length lookup: slot after a release, else the current oldest
	assign rd_slot = (kind == KIND_RELEASE && ring_any) ? slot_next(rs_q) : rs_q;
	assign len_rd  = slot_len_q[rd_slot];

	always_comb begin
		cnt_d     = cnt_q;
		skip_d    = skip_q;
		fill_d    = fill_q;
		ws_d      = ws_q;
		rs_d      = rs_q;
		ready_d   = ready_q;
		overrun_d = overrun_q;
		closing   = 1'b0;
		close_len = fill_q;
		len_we    = 1'b0;
		ram_we    = 1'b0;
		read_hit  = 1'b0;
		case (kind)
			KIND_TICK: begin
				cnt_d = cnt_inc;
				if (fill_q != '0 && cnt_inc >= timeout_q) begin
					closing = 1'b1;
				end
			end
			KIND_EDGE: begin
				cnt_d = '0;
				if (skip_q) begin
					skip_d = 1'b0;
				end else begin
					ram_we = ~ring_full;
					fill_d = fill_inc;
					if (fill_inc == LW'(FRAME_CAPACITY - 1)) begin
						closing   = 1'b1;
						close_len = fill_inc;
					end
				end
			end
			KIND_READ: begin
				if (ring_any && 9'(read_index) < 9'(len_rd)
						&& 9'(read_index) < 9'(FRAME_CAPACITY)) begin
					read_hit = 1'b1;
				end
			end
			KIND_RELEASE: begin
				if (ring_any) begin
					rs_d    = rd_slot;
					ready_d = ready_q - RW'(1);
				end
			end
			default: begin
			end
		endcase
		if (closing) begin
			fill_d = '0;
			skip_d = 1'b1;
			if (ring_full) begin
				overrun_d = 1'b1;
			end else begin
				len_we  = 1'b1;
				ws_d    = slot_next(ws_q);
				ready_d = ready_q + RW'(1);
			end
		end
	end

	// frame closing into an empty ring is its own oldest
	always_comb begin
		if (ready_d == '0) begin
			oldest = '0;
		end else if (len_we && !ring_any) begin
			oldest = close_len;
		end else begin
			oldest = len_rd;
		end
	end

	assign status.read_valid    = read_hit;
	assign status.frames_ready  = 3'(ready_d);
	assign status.oldest_length = 7'(oldest);
	assign status.frame_closed  = closing;
	assign status.overrun       = overrun_d;

	assign ram_re    = accept & read_hit;
	assign ram_wdata = cnt_q;
	assign ram_waddr = AW'(ws_q) * AW'(FRAME_CAPACITY) + AW'(fill_q);
	assign ram_raddr = AW'(rs_q) * AW'(FRAME_CAPACITY) + AW'(read_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_DEFAULT;
			cnt_q     <= '0;
			skip_q    <= 1'b1;
			fill_q    <= '0;
			ws_q      <= '0;
			rs_q      <= '0;
			ready_q   <= '0;
			overrun_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q     <= cnt_d;
				skip_q    <= skip_d;
				fill_q    <= fill_d;
				ws_q      <= ws_d;
				rs_q      <= rs_d;
				ready_q   <= ready_d;
				overrun_q <= overrun_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && len_we) begin
			slot_len_q[ws_q] <= close_len;
		end
	end

endmodule

// ===== rtl/ir_pulse_width_frame_capture.sv =====
// IR receiver pulse-width capture with a ring of frame slots.
//
// Input channel (in_valid / in_stall): one word per event. kind selects a
// microsecond tick, a receiver edge, a read of the oldest frame at
// read_index, or a release of the oldest frame. Every word yields exactly
// one output word on out_valid / out_stall with the read data and status.
// Stage 1 covers the registered read of the width store, stage 2 is the
// output register.
// Throughput: one word per cycle while in_stall is low; state update and
// the single store access both happen in the accept cycle, so nothing loops
// across words. Receiver stall: the output word holds; stage 1 keeps one
// more word, and only when both are full does in_stall rise.
// The user writes idle_timeout_us via cfg_we / cfg_wdata only while idle;
// the block does not enforce this. Reset: timeout 10000 us, counters, ring
// pointers and overrun flag clear, the first edge of a frame is skipped.
// The width store and slot lengths are not cleared; only written entries
// are ever read back.
`include "assert_macros.svh"

module ir_pulse_width_frame_capture (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [6:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pulse_width,
	output logic        read_valid,
	output logic [2:0]  frames_ready,
	output logic [6:0]  oldest_length,
	output logic        frame_closed,
	output logic        overrun,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	import irpw_pkg::*;

	localparam int AW = $clog2(FRAME_SLOTS * FRAME_CAPACITY);

	logic          accept;
	logic          advance;
	status_t       status;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;

	logic          valid_s1;
	status_t       status_s1;
	logic          out_valid_q;
	logic [15:0]   pulse_width_q;
	status_t       status_q;

	// stage 1 moves on when the output register is empty or being taken
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	irpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind_t'(kind)),
		.read_index(read_index),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// write gated by accept here; read enable comes gated from the controller
	irpw_ram #(
		.WIDTH(16),
		.DEPTH(FRAME_SLOTS * FRAME_CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (accept & ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
		if (advance) begin
			status_q      <= status_s1;
			// store data stays put until the next read, which needs stage 1 free
			pulse_width_q <= status_s1.read_valid ? ram_rdata : 16'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign pulse_width   = pulse_width_q;
	assign read_valid    = status_q.read_valid;
	assign frames_ready  = status_q.frames_ready;
	assign oldest_length = status_q.oldest_length;
	assign frame_closed  = status_q.frame_closed;
	assign overrun       = status_q.overrun;

	`ASSERT_IMPLY(a_read_needs_frame, clk, arst_n, out_valid_q && status_q.read_valid,
		status_q.frames_ready != 3'd0, "read hit reported with no frame waiting")
	`ASSERT_IMPLY(a_empty_has_no_length, clk, arst_n,
		out_valid_q && status_q.frames_ready == 3'd0,
		status_q.oldest_length == 7'd0, "oldest length nonzero with empty ring")
	`ASSERT_NEXT(a_store_read_lands, clk, arst_n, ram_re,
		valid_s1 && status_s1.read_valid, "store read without a read word in stage 1")

endmodule
